### sv/rtpi_pkg.sv
// rtpi_pkg: shared types, constants and codes for the ray / triangle-plane block
// no dependencies; imported by every module of the block
package rtpi_pkg;

	// result clamp width and internal stage counts
	localparam int COORD_WIDTH = 32;
	localparam int OUT_BITS    = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam int QDEPTH      = 8;
	localparam int QAW         = $clog2(QDEPTH);
	localparam int FRONT_LAT   = 4;
	localparam int SQRT_STEPS  = 32;
	localparam int UDIV_STEPS  = 31;
	localparam int TDIV_STEPS  = 32;

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_PARALLEL = 2'd1,
		ST_DEGEN    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CFG_ORIGIN_X = 3'd0,
		CFG_ORIGIN_Y = 3'd1,
		CFG_ORIGIN_Z = 3'd2,
		CFG_DIR_X    = 3'd3,
		CFG_DIR_Y    = 3'd4,
		CFG_DIR_Z    = 3'd5,
		CFG_EPS      = 3'd6
	} cfg_index_t;

	typedef logic [2:0][31:0] vec32_t;

	// input item: three vertices, Q16.16
	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] c_z;
	} tri_item_t;

	// result item
	typedef struct packed {
		status_t            status;
		logic signed [31:0] hit_x;
		logic signed [31:0] hit_y;
		logic signed [31:0] hit_z;
		logic signed [31:0] ray_distance;
		logic               saturated;
	} result_t;

	// configured ray
	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
		logic [30:0]        eps;
	} ray_cfg_t;

	// queue entry: vertex a and raw normal
	typedef struct packed {
		vec32_t           a;
		logic [2:0][62:0] n;
		logic             degen;
	} qent_t;

	// unit normal handed from normalizer to back end
	typedef struct packed {
		vec32_t a;
		vec32_t u;
		logic   degen;
	} unit_t;

	// queue status seen by the top level
	typedef struct packed {
		logic [QAW:0] count;
		logic         empty;
	} qstat_t;

endpackage

### sv/ray_triangle_plane_intersect.sv
// Ray / triangle-plane intersection, top level: configuration registers, busy,
// and the front end, queue, normalizer and back end; depends on rtpi_pkg
//
// The block takes one triangle per clock cycle (start high while busy is low) and
// returns one result per triangle, in order; the pipeline holds the 32-step
// square root, the 31-step unit-normal division and the 32-step distance
// division, each one step per pipeline stage.
// Results appear on result for exactly one cycle with result_valid high and cannot
// be held off. Configuration writes are taken every cycle (cfg_ready is always
// high) and must only be made while no triangle is in flight.
module ray_triangle_plane_intersect (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rtpi_pkg::tri_item_t vertices,
	output logic                result_valid,
	output rtpi_pkg::result_t   result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import rtpi_pkg::*;

	ray_cfg_t ray_q;
	logic     take;
	logic     push;
	qent_t    entry;
	logic     q_valid;
	qent_t    q_data;
	qstat_t   q_stat;
	logic     n_valid;
	unit_t    n_unit;

	// credit check: the front end never holds more than its stage count
	assign busy      = (q_stat.count >= (QAW+1)'(QDEPTH - FRONT_LAT));
	assign take      = start && !busy;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_q.ox  <= '0;
			ray_q.oy  <= '0;
			ray_q.oz  <= '0;
			ray_q.dx  <= 32'sd1073741824;
			ray_q.dy  <= '0;
			ray_q.dz  <= '0;
			ray_q.eps <= 31'd10737;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_ORIGIN_X: ray_q.ox  <= cfg_data;
				CFG_ORIGIN_Y: ray_q.oy  <= cfg_data;
				CFG_ORIGIN_Z: ray_q.oz  <= cfg_data;
				CFG_DIR_X:    ray_q.dx  <= cfg_data;
				CFG_DIR_Y:    ray_q.dy  <= cfg_data;
				CFG_DIR_Z:    ray_q.dz  <= cfg_data;
				CFG_EPS:      ray_q.eps <= cfg_data[30:0];
				default:      ray_q     <= ray_q;
			endcase
		end
	end

	rtpi_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (vertices),
		.push   (push),
		.entry  (entry)
	);

	rtpi_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.rvalid (q_valid),
		.rdata  (q_data),
		.stat   (q_stat)
	);

	rtpi_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_entry  (q_data),
		.out_valid (n_valid),
		.out_unit  (n_unit)
	);

	rtpi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (n_valid),
		.in_unit    (n_unit),
		.ray        (ray_q),
		.out_valid  (result_valid),
		.out_result (result)
	);

	// queue never takes an item while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_stat.count < (QAW+1)'(QDEPTH)))
		else $error("queue overflow");

	// non-hit results carry zero payload
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status != ST_HIT) |->
			(result.hit_x == '0 && result.hit_y == '0 && result.hit_z == '0
			&& result.ray_distance == '0 && !result.saturated))
		else $error("non-hit result with payload");

	// an empty queue with an idle front end stays empty next cycle
	a_queue_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.empty && !push) |=> q_stat.empty)
		else $error("queue filled without a push");

endmodule

### sv/rtpi_front.sv
// rtpi_front: takes triangles, scales the edges and forms the raw plane normal
// depends on rtpi_pkg
module rtpi_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  rtpi_pkg::tri_item_t   item,
	output logic                  push,
	output rtpi_pkg::qent_t       entry
);
	import rtpi_pkg::*;

	// smallest right shift (0..2) that brings all components into 31 signed bits
	function automatic logic [1:0] edge_shift(logic signed [32:0] x, logic signed [32:0] y,
			logic signed [32:0] z);
		logic f0, f1;
		logic [1:0] s;
		f0 = (x[32:30] == 3'b000 || x[32:30] == 3'b111)
			&& (y[32:30] == 3'b000 || y[32:30] == 3'b111)
			&& (z[32:30] == 3'b000 || z[32:30] == 3'b111);
		f1 = (x[32] == x[31]) && (y[32] == y[31]) && (z[32] == z[31]);
		if (f0)
			s = 2'd0;
		else if (f1)
			s = 2'd1;
		else
			s = 2'd2;
		return s;
	endfunction

	tri_item_t          item_s1;
	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [30:0] e_s2 [3];
	logic signed [30:0] f_s2 [3];
	vec32_t             a_s2, a_s3;
	logic signed [61:0] pr_s3 [6];
	qent_t              entry_s4;

	logic signed [32:0] e_c [3];
	logic signed [32:0] f_c [3];
	logic [1:0]         es_c, fs_c;
	logic signed [30:0] es_v [3];
	logic signed [30:0] fs_v [3];
	logic [2:0][62:0]   n_c;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// edges and their scaling
	always_comb begin
		e_c[0] = 33'(item_s1.b_x) - 33'(item_s1.a_x);
		e_c[1] = 33'(item_s1.b_y) - 33'(item_s1.a_y);
		e_c[2] = 33'(item_s1.b_z) - 33'(item_s1.a_z);
		f_c[0] = 33'(item_s1.c_x) - 33'(item_s1.a_x);
		f_c[1] = 33'(item_s1.c_y) - 33'(item_s1.a_y);
		f_c[2] = 33'(item_s1.c_z) - 33'(item_s1.a_z);
		es_c = edge_shift(e_c[0], e_c[1], e_c[2]);
		fs_c = edge_shift(f_c[0], f_c[1], f_c[2]);
		for (int i = 0; i < 3; i++) begin
			es_v[i] = 31'(e_c[i] >>> es_c);
			fs_v[i] = 31'(f_c[i] >>> fs_c);
		end
	end

	// cross product differences
	always_comb begin
		n_c[0] = 63'(pr_s3[0]) - 63'(pr_s3[1]);
		n_c[1] = 63'(pr_s3[2]) - 63'(pr_s3[3]);
		n_c[2] = 63'(pr_s3[4]) - 63'(pr_s3[5]);
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= item;
		for (int i = 0; i < 3; i++) begin
			e_s2[i] <= es_v[i];
			f_s2[i] <= fs_v[i];
		end
		a_s2 <= {item_s1.a_z, item_s1.a_y, item_s1.a_x};
		pr_s3[0] <= e_s2[1] * f_s2[2];
		pr_s3[1] <= e_s2[2] * f_s2[1];
		pr_s3[2] <= e_s2[2] * f_s2[0];
		pr_s3[3] <= e_s2[0] * f_s2[2];
		pr_s3[4] <= e_s2[0] * f_s2[1];
		pr_s3[5] <= e_s2[1] * f_s2[0];
		a_s3 <= a_s2;
		entry_s4.a     <= a_s3;
		entry_s4.n     <= n_c;
		entry_s4.degen <= (n_c == '0);
	end

	assign push  = vld_s4;
	assign entry = entry_s4;

endmodule

### sv/rtpi_queue.sv
// rtpi_queue: short queue between the front end and the normalizer
// depends on rtpi_pkg
module rtpi_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rtpi_pkg::qent_t   wdata,
	output logic              rvalid,
	output rtpi_pkg::qent_t   rdata,
	output rtpi_pkg::qstat_t  stat
);
	import rtpi_pkg::*;

	qent_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;
	logic           pop;

	// the consumer never stalls: pop whenever something is held
	assign pop    = (cnt_q != '0);
	assign rvalid = pop;
	assign rdata  = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	assign stat.count = cnt_q;
	assign stat.empty = (cnt_q == '0);

endmodule

### sv/rtpi_norm.sv
// rtpi_norm: normalizes the raw normal: magnitude scaling, pipelined square root
// and pipelined unit division; depends on rtpi_pkg
module rtpi_norm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  rtpi_pkg::qent_t  in_entry,
	output logic             out_valid,
	output rtpi_pkg::unit_t  out_unit
);
	import rtpi_pkg::*;

	typedef struct packed {
		logic [63:0]      x;
		logic [63:0]      res;
		logic [2:0][30:0] m;
		logic [2:0]       neg;
		vec32_t           a;
		logic             degen;
	} sq_t;

	typedef struct packed {
		logic [31:0] r;
		logic [30:0] nlo;
		logic [30:0] q;
	} ud_lane_t;

	typedef struct packed {
		ud_lane_t [2:0] lane;
		logic [31:0]    len;
		logic [2:0]     neg;
		vec32_t         a;
		logic           degen;
	} ud_t;

	// one step of the digit-by-digit square root
	function automatic sq_t sqrt_step(sq_t p, int k);
		sq_t o;
		logic [63:0] bitv, trial;
		o     = p;
		bitv  = 64'(1) << (62 - 2 * k);
		trial = p.res + bitv;
		if (p.x >= trial) begin
			o.x   = p.x - trial;
			o.res = (p.res >> 1) + bitv;
		end else begin
			o.res = p.res >> 1;
		end
		return o;
	endfunction

	// one restoring division step
	function automatic ud_lane_t udiv_step(ud_lane_t p, logic [31:0] d);
		ud_lane_t o;
		logic [32:0] t;
		t     = {p.r, p.nlo[30]};
		o.nlo = {p.nlo[29:0], 1'b0};
		if (t >= {1'b0, d}) begin
			o.r = 32'(t - {1'b0, d});
			o.q = {p.q[29:0], 1'b1};
		end else begin
			o.r = t[31:0];
			o.q = {p.q[29:0], 1'b0};
		end
		return o;
	endfunction

	// one division stage: all three lanes step, the rest rides along
	function automatic ud_t udiv_stage(ud_t p);
		ud_t o;
		o = p;
		for (int i = 0; i < 3; i++)
			o.lane[i] = udiv_step(p.lane[i], p.len);
		return o;
	endfunction

	localparam int NV = 5 + SQRT_STEPS + 1 + UDIV_STEPS;

	logic [NV-1:0]    vld_s;
	logic [2:0][61:0] m_s1, m_s2;
	logic [61:0]      or_s1;
	logic [2:0]       neg_s1, neg_s2, neg_s3, neg_s4;
	vec32_t           a_s1, a_s2, a_s3, a_s4;
	logic             dg_s1, dg_s2, dg_s3, dg_s4;
	logic [5:0]       bl_s2;
	logic [2:0][30:0] m31_s3, m31_s4;
	logic [2:0][61:0] sq_s4;
	sq_t              sr_s [SQRT_STEPS+1];
	ud_t              ud_s [UDIV_STEPS+1];

	logic [2:0][61:0] mag_c;
	logic [61:0]      or_c;
	logic [5:0]       bl_c;
	logic [2:0][30:0] m31_c;
	logic [63:0]      sum_c;
	ud_t              prep_c;
	logic [61:0]      num_c;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else
			vld_s <= {vld_s[NV-2:0], in_valid};
	end

	// magnitudes and their combined bit pattern
	always_comb begin
		for (int i = 0; i < 3; i++)
			mag_c[i] = in_entry.n[i][62] ? 62'(~in_entry.n[i] + 63'd1) : in_entry.n[i][61:0];
		or_c = mag_c[0] | mag_c[1] | mag_c[2];
	end

	// bit length of the largest magnitude
	always_comb begin
		bl_c = '0;
		for (int i = 0; i < 62; i++)
			if (or_s1[i])
				bl_c = 6'(i + 1);
	end

	// scale so the largest magnitude has 31 significant bits
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (bl_s2 > 6'd31)
				m31_c[i] = 31'(m_s2[i] >> (bl_s2 - 6'd31));
			else
				m31_c[i] = 31'(m_s2[i] << (6'd31 - bl_s2));
		end
		sum_c = 64'(sq_s4[0]) + 64'(sq_s4[1]) + 64'(sq_s4[2]);
	end

	// dividends m * 2^30 + len / 2, split for the quotient steps
	always_comb begin
		prep_c.len   = sr_s[SQRT_STEPS].res[31:0];
		prep_c.neg   = sr_s[SQRT_STEPS].neg;
		prep_c.a     = sr_s[SQRT_STEPS].a;
		prep_c.degen = sr_s[SQRT_STEPS].degen;
		num_c        = '0;
		for (int i = 0; i < 3; i++) begin
			num_c = (62'(sr_s[SQRT_STEPS].m[i]) << 30) + 62'(prep_c.len >> 1);
			prep_c.lane[i].r   = {1'b0, num_c[61:31]};
			prep_c.lane[i].nlo = num_c[30:0];
			prep_c.lane[i].q   = '0;
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		m_s1   <= mag_c;
		or_s1  <= or_c;
		a_s1   <= in_entry.a;
		dg_s1  <= in_entry.degen;
		for (int i = 0; i < 3; i++)
			neg_s1[i] <= in_entry.n[i][62];
		m_s2   <= m_s1;
		bl_s2  <= bl_c;
		neg_s2 <= neg_s1;
		a_s2   <= a_s1;
		dg_s2  <= dg_s1;
		m31_s3 <= m31_c;
		neg_s3 <= neg_s2;
		a_s3   <= a_s2;
		dg_s3  <= dg_s2;
		for (int i = 0; i < 3; i++)
			sq_s4[i] <= 62'(m31_s3[i]) * 62'(m31_s3[i]);
		m31_s4 <= m31_s3;
		neg_s4 <= neg_s3;
		a_s4   <= a_s3;
		dg_s4  <= dg_s3;
		sr_s[0].x     <= sum_c;
		sr_s[0].res   <= '0;
		sr_s[0].m     <= m31_s4;
		sr_s[0].neg   <= neg_s4;
		sr_s[0].a     <= a_s4;
		sr_s[0].degen <= dg_s4;
		for (int k = 0; k < SQRT_STEPS; k++)
			sr_s[k+1] <= sqrt_step(sr_s[k], k);
		ud_s[0] <= prep_c;
		for (int j = 0; j < UDIV_STEPS; j++)
			ud_s[j+1] <= udiv_stage(ud_s[j]);
	end

	// signed unit normal
	always_comb begin
		out_unit.a     = ud_s[UDIV_STEPS].a;
		out_unit.degen = ud_s[UDIV_STEPS].degen;
		for (int i = 0; i < 3; i++) begin
			if (ud_s[UDIV_STEPS].neg[i])
				out_unit.u[i] = 32'(-{1'b0, ud_s[UDIV_STEPS].lane[i].q});
			else
				out_unit.u[i] = {1'b0, ud_s[UDIV_STEPS].lane[i].q};
		end
	end

	assign out_valid = vld_s[NV-1];

endmodule

### sv/rtpi_back.sv
// rtpi_back: dot products, parallel test, pipelined distance division, hit point
// and saturation; depends on rtpi_pkg
module rtpi_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  rtpi_pkg::unit_t    in_unit,
	input  rtpi_pkg::ray_cfg_t ray,
	output logic               out_valid,
	output rtpi_pkg::result_t  out_result
);
	import rtpi_pkg::*;

	typedef struct packed {
		logic [63:0] r;
		logic [31:0] lo;
		logic [31:0] q;
		logic [63:0] dd;
		logic        neg;
		logic        big;
		status_t     st;
	} td_t;

	// one restoring division step
	function automatic td_t tdiv_step(td_t p);
		td_t o;
		logic [64:0] t;
		o    = p;
		t    = {p.r, p.lo[31]};
		o.lo = {p.lo[30:0], 1'b0};
		if (t >= {1'b0, p.dd}) begin
			o.r = 64'(t - {1'b0, p.dd});
			o.q = {p.q[30:0], 1'b1};
		end else begin
			o.r = t[63:0];
			o.q = {p.q[30:0], 1'b0};
		end
		return o;
	endfunction

	localparam logic [32:0]        LIM  = 33'(1) << (OUT_BITS - 1);
	localparam logic signed [34:0] HMAX = (35'sd1 <<< (OUT_BITS - 1)) - 35'sd1;
	localparam logic signed [34:0] HMIN = -(35'sd1 <<< (OUT_BITS - 1));
	localparam int                 NV   = 4 + TDIV_STEPS + 3;

	logic [NV-1:0]      vld_s;
	logic signed [32:0] diff_s1 [3];
	vec32_t             u_s1;
	logic               dg_s1, dg_s2, dg_s3;
	logic signed [63:0] pd_s2 [3];
	logic signed [64:0] pn_s2 [3];
	logic signed [63:0] dn_s3, num_s3;
	td_t                td_s [TDIV_STEPS+1];
	logic signed [31:0] dist_s5, dist_s6;
	logic               sat_s5, sat_s6;
	status_t            st_s5, st_s6;
	logic signed [63:0] ps_s6 [3];
	result_t            out_s7;

	logic signed [31:0] o_c [3];
	logic signed [31:0] d_c [3];
	logic signed [31:0] u_c [3];
	logic signed [63:0] pd_c [3];
	logic signed [64:0] pn_c [3];
	logic signed [63:0] num_c;
	logic [63:0]        dmag_c, nmag_c, h_c, r0_c;
	td_t                tdin_c;
	td_t                tdend;
	logic [32:0]        qx_c;
	logic signed [32:0] dist_c;
	logic               sat_c;
	logic signed [63:0] rnd_c [3];
	logic signed [34:0] hp_c [3];
	logic signed [34:0] hc_c [3];
	logic               hsat_c;

	assign o_c[0] = ray.ox;
	assign o_c[1] = ray.oy;
	assign o_c[2] = ray.oz;
	assign d_c[0] = ray.dx;
	assign d_c[1] = ray.dy;
	assign d_c[2] = ray.dz;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else
			vld_s <= {vld_s[NV-2:0], in_valid};
	end

	// products for direction and origin dot products
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			u_c[i]  = $signed(u_s1[i]);
			pd_c[i] = d_c[i] * u_c[i];
			pn_c[i] = diff_s1[i] * u_c[i];
		end
		num_c = 64'(pn_s2[0] >>> 2) + 64'(pn_s2[1] >>> 2) + 64'(pn_s2[2] >>> 2);
	end

	// classify and set up the distance division
	always_comb begin
		dmag_c = dn_s3[63] ? 64'(-dn_s3) : 64'(dn_s3);
		nmag_c = num_s3[63] ? 64'(-num_s3) : 64'(num_s3);
		h_c    = dmag_c >> 1;
		r0_c   = nmag_c + {32'd0, h_c[63:32]};
		tdin_c.r   = r0_c;
		tdin_c.lo  = h_c[31:0];
		tdin_c.q   = '0;
		tdin_c.dd  = dmag_c;
		tdin_c.big = (r0_c >= dmag_c);
		tdin_c.neg = (num_s3 != '0) && (num_s3[63] == dn_s3[63]);
		if (dg_s3)
			tdin_c.st = ST_DEGEN;
		else if (dmag_c == '0 || dmag_c < (64'(ray.eps) << 30))
			tdin_c.st = ST_PARALLEL;
		else
			tdin_c.st = ST_HIT;
	end

	// clamp the distance
	assign tdend = td_s[TDIV_STEPS];
	always_comb begin
		qx_c  = {1'b0, tdend.q};
		sat_c = 1'b0;
		if (tdend.neg) begin
			if (tdend.big || qx_c > LIM) begin
				sat_c  = 1'b1;
				dist_c = -$signed(LIM);
			end else begin
				dist_c = -$signed(qx_c);
			end
		end else begin
			if (tdend.big || qx_c > LIM - 33'd1) begin
				sat_c  = 1'b1;
				dist_c = $signed(LIM - 33'd1);
			end else begin
				dist_c = $signed(qx_c);
			end
		end
	end

	// hit point with rounding and clamp
	always_comb begin
		hsat_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			rnd_c[i] = (ps_s6[i] + 64'sd536870912) >>> 30;
			hp_c[i]  = 35'(o_c[i]) + 35'(rnd_c[i]);
			if (hp_c[i] > HMAX) begin
				hc_c[i] = HMAX;
				hsat_c  = 1'b1;
			end else if (hp_c[i] < HMIN) begin
				hc_c[i] = HMIN;
				hsat_c  = 1'b1;
			end else begin
				hc_c[i] = hp_c[i];
			end
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			diff_s1[i] <= 33'(o_c[i]) - 33'($signed(in_unit.a[i]));
		u_s1  <= in_unit.u;
		dg_s1 <= in_unit.degen;
		for (int i = 0; i < 3; i++) begin
			pd_s2[i] <= pd_c[i];
			pn_s2[i] <= pn_c[i];
		end
		dg_s2  <= dg_s1;
		dn_s3  <= pd_s2[0] + pd_s2[1] + pd_s2[2];
		num_s3 <= num_c;
		dg_s3  <= dg_s2;
		td_s[0] <= tdin_c;
		for (int j = 0; j < TDIV_STEPS; j++)
			td_s[j+1] <= tdiv_step(td_s[j]);
		dist_s5 <= 32'(dist_c);
		sat_s5  <= sat_c;
		st_s5   <= tdend.st;
		for (int i = 0; i < 3; i++)
			ps_s6[i] <= d_c[i] * dist_s5;
		dist_s6 <= dist_s5;
		sat_s6  <= sat_s5;
		st_s6   <= st_s5;
		out_s7.status <= st_s6;
		if (st_s6 == ST_HIT) begin
			out_s7.hit_x        <= hc_c[0][31:0];
			out_s7.hit_y        <= hc_c[1][31:0];
			out_s7.hit_z        <= hc_c[2][31:0];
			out_s7.ray_distance <= dist_s6;
			out_s7.saturated    <= sat_s6 | hsat_c;
		end else begin
			out_s7.hit_x        <= '0;
			out_s7.hit_y        <= '0;
			out_s7.hit_z        <= '0;
			out_s7.ray_distance <= '0;
			out_s7.saturated    <= 1'b0;
		end
	end

	assign out_valid  = vld_s[NV-1];
	assign out_result = out_s7;

endmodule
